// ===== src/sct_pkg.sv =====
// ---------------------------------------------------------------------------
// sct_pkg: shared constants for the sine/cosine series pipeline
// Fixed-point constants, series length and reciprocal tables.
// ---------------------------------------------------------------------------
package sct_pkg;

  // number of series terms after the first (4..20)
  localparam int SERIES_TERMS = 20;
  localparam int MAX_TERMS    = 20;
  localparam int NUM_TERMS    = (SERIES_TERMS < MAX_TERMS) ? SERIES_TERMS : MAX_TERMS;

  // 1/(2pi) in Q0.32, 2pi in Q3.29
  localparam logic [31:0] INV_TWO_PI = 32'd683565275;
  localparam logic [31:0] TWO_PI     = 32'd3373259426;
  // 0.5 in Q.56
  localparam logic signed [63:0] HALF_Q56 = 64'sd36028797018963968;
  // 1.0 in Q4.28
  localparam logic [31:0] ONE_Q28 = 32'd268435456;

  localparam int SUM_W = 36;

  typedef logic [31:0] rcp_t;

  // floor(2^32 / ((2i)(2i+1)))
  localparam rcp_t SIN_RCP [MAX_TERMS] = '{
    32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323, 32'd39045157,
    32'd27531841,  32'd20452225,  32'd15790320,  32'd12558383, 32'd10226112,
    32'd8488077,   32'd7158278,   32'd6118187,   32'd5289368,  32'd4618244,
    32'd4067203,   32'd3609216,   32'd3224449,   32'd2898088,  32'd2618882
  };

  // floor(2^32 / ((2i-1)(2i)))
  localparam rcp_t COS_RCP [MAX_TERMS] = '{
    32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844, 32'd47721858,
    32'd32537631,   32'd23598721,  32'd17895697,  32'd14035840, 32'd11302545,
    32'd9296466,    32'd7780737,   32'd6607641,   32'd5681173,  32'd4936744,
    32'd4329604,    32'd3827956,   32'd3408704,   32'd3054742,  32'd2753184
  };

  // state of one item between series stages
  typedef struct packed {
    logic                    rneg;
    logic [31:0]             r2;
    logic [31:0]             ts;
    logic [31:0]             tc;
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] c;
  } sct_data_t;

endpackage

// ===== src/sct_if.sv =====
// ---------------------------------------------------------------------------
// sct_if: valid/ready channels of the sine/cosine pipeline
// Angle channel and result channel.
// ---------------------------------------------------------------------------
interface sct_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface sct_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sine;
  logic signed [31:0] cosine;
  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// ===== src/sct_term.sv =====
// ---------------------------------------------------------------------------
// sct_term: one series term for sine and cosine
// Two register stages: scale factor from r^2, then term update and sum.
// ---------------------------------------------------------------------------
module sct_term (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [31:0]       sin_rcp,
  input  logic [31:0]       cos_rcp,
  input  logic              even,
  input  logic              valid,
  input  sct_pkg::sct_data_t data,
  output logic              valid_o,
  output sct_pkg::sct_data_t data_o
);
  import sct_pkg::*;

  logic        valid_a;
  sct_data_t   data_a;
  logic [31:0] fs;
  logic [31:0] fc;
  logic [63:0] ps;
  logic [63:0] pc;
  logic [63:0] ms;
  logic [63:0] mc;
  logic [31:0] ts_next;
  logic [31:0] tc_next;
  logic        sub_s;

  // scale factors
  assign ps = {32'd0, data.r2} * {32'd0, sin_rcp};
  assign pc = {32'd0, data.r2} * {32'd0, cos_rcp};

  // term magnitudes, truncated toward zero
  assign ms      = {32'd0, data_a.ts} * {32'd0, fs};
  assign mc      = {32'd0, data_a.tc} * {32'd0, fc};
  assign ts_next = ms[59:28];
  assign tc_next = mc[59:28];
  assign sub_s   = even ^ data_a.rneg;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      valid_a <= valid;
      valid_o <= valid_a;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= data;
      fs     <= ps[63:32];
      fc     <= pc[63:32];
      data_o.rneg <= data_a.rneg;
      data_o.r2   <= data_a.r2;
      data_o.ts   <= ts_next;
      data_o.tc   <= tc_next;
      data_o.s    <= sub_s ? data_a.s - $signed({4'd0, ts_next})
                           : data_a.s + $signed({4'd0, ts_next});
      data_o.c    <= even ? data_a.c - $signed({4'd0, tc_next})
                          : data_a.c + $signed({4'd0, tc_next});
    end
  end

endmodule

// ===== src/sine_cosine_taylor.sv =====
// ---------------------------------------------------------------------------
// sine_cosine_taylor: pipelined sine and cosine by Taylor series
//
// angle_ch (sink) takes one angle word in radians, signed Q8.24.
// result_ch (source) gives sine and cosine of it as one word, signed Q2.30.
// The angle is reduced to [-pi, pi) by a multiply with 1/(2pi), then each
// series term takes two register stages (scale factor, term multiply).
// An accepted angle passes the front stages (k, r, r^2), the series terms
// and the output stage. Throughput: one word per cycle while result_ch does not stall.
// Every stage advances together: when result_ch stalls with a word held,
// the whole pipeline freezes and angle_ch.ready drops; nothing is lost
// or repeated. Results come out in the order angles went in.
// Reset (rst, synchronous) clears all valid bits; no items are in flight
// afterwards. No state is kept between angles.
// ---------------------------------------------------------------------------
module sine_cosine_taylor (
  input  logic         clk,
  input  logic         rst,
  sct_angle_if.sink    angle_ch,
  sct_result_if.source result_ch
);
  import sct_pkg::*;

  logic en;

  logic               v1, v2, v3;
  logic signed [31:0] x1;
  logic signed [5:0]  k1;
  logic               rneg2;
  logic [31:0]        rm2;

  logic signed [63:0] vprod;
  logic signed [63:0] vsum;
  logic signed [39:0] rfull;
  logic [63:0]        rsq;

  logic      tv [NUM_TERMS+1];
  sct_data_t td [NUM_TERMS+1];

  logic signed [SUM_W+1:0] s4;
  logic signed [SUM_W+1:0] c4;

  assign en = result_ch.ready | ~result_ch.valid;
  assign angle_ch.ready = en;

  // stage 1: k = floor(x/(2pi) + 0.5)
  assign vprod = angle_ch.angle * $signed({32'd0, INV_TWO_PI});
  assign vsum  = vprod + HALF_Q56;

  // stage 2: r = x*32 - k*2pi in Q3.29
  assign rfull = $signed({{3{x1[31]}}, x1, 5'd0})
               - ($signed({{34{k1[5]}}, k1}) * $signed({8'd0, TWO_PI}));

  // stage 3: r^2 in Q4.28
  assign rsq = {32'd0, rm2} * {32'd0, rm2};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_ch.valid <= 1'b0;
    end else if (en) begin
      v1 <= angle_ch.valid;
      v2 <= v1;
      v3 <= v2;
      result_ch.valid <= tv[NUM_TERMS];
    end
  end

  // payload of the front stages
  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= angle_ch.angle;
      k1    <= vsum[61:56];
      rneg2 <= rfull[39];
      rm2   <= rfull[39] ? 32'(-rfull) : rfull[31:0];
      td[0].rneg <= rneg2;
      td[0].r2   <= rsq[61:30];
      td[0].ts   <= {1'b0, rm2[31:1]};
      td[0].tc   <= ONE_Q28;
      td[0].s    <= rneg2 ? -$signed({5'd0, rm2[31:1]}) : $signed({5'd0, rm2[31:1]});
      td[0].c    <= $signed({4'd0, ONE_Q28});
    end
  end

  assign tv[0] = v3;

  // series terms
  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
    sct_term u_term (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .sin_rcp (SIN_RCP[i]),
      .cos_rcp (COS_RCP[i]),
      .even    ((i % 2) == 0),
      .valid   (tv[i]),
      .data    (td[i]),
      .valid_o (tv[i+1]),
      .data_o  (td[i+1])
    );
  end

  // output stage: scale to Q2.30 and saturate
  assign s4 = {td[NUM_TERMS].s, 2'b00};
  assign c4 = {td[NUM_TERMS].c, 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      if (s4 > 38'sd2147483647)       result_ch.sine <= 32'h7fffffff;
      else if (s4 < -38'sd2147483648) result_ch.sine <= 32'h80000000;
      else                            result_ch.sine <= s4[31:0];
      if (c4 > 38'sd2147483647)       result_ch.cosine <= 32'h7fffffff;
      else if (c4 < -38'sd2147483648) result_ch.cosine <= 32'h80000000;
      else                            result_ch.cosine <= c4[31:0];
    end
  end

endmodule

// ===== src/sct_checker.sv =====
// ---------------------------------------------------------------------------
// sct_checker: port-level checks for sine_cosine_taylor
// Stall behavior, reset and back-pressure coupling.
// ---------------------------------------------------------------------------
module sct_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] sine,
  input logic signed [31:0] cosine
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sine) && $stable(cosine))
    else $error("result word changed while stalled");

  // reset leaves no word in flight
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input is taken whenever the output side can move
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output free");

  // input stalls only while a result is held back
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind sine_cosine_taylor sct_checker u_sct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (angle_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .sine      (result_ch.sine),
  .cosine    (result_ch.cosine)
);

// ===== tb/sct_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sct_scoreboard: result predictor and scoreboard for sine_cosine_taylor
// Watches the angle and result channels, computes the expected sine and
// cosine of every accepted angle in fixed point and compares in order.
// ---------------------------------------------------------------------------
module sct_scoreboard (
  input  logic         clk,
  input  logic         rst,
  sct_angle_if.sink    angle_ch,
  sct_result_if.sink   result_ch,
  output int           errors,
  output int           pending
);
  import sct_pkg::*;

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_t;

  trig_t trig_q[$];

  // saturate a Q4.28 sum into Q2.30
  function automatic logic signed [31:0] sat_q230(input longint sum);
    longint v;
    v = sum * 4;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // range reduction then both series
  function automatic trig_t calc_trig(input logic signed [31:0] angle);
    longint x, v, k, r;
    logic rneg;
    logic [63:0] rm, r2, t, f;
    longint s, c;
    trig_t res;
    x = angle;
    v = x * longint'(INV_TWO_PI) + HALF_Q56;
    k = v >>> 56;
    r = x * 32 - k * longint'(TWO_PI);
    rneg = r < 0;
    rm = rneg ? -r : r;
    r2 = (rm * rm) >> 30;
    t = rm >> 1;
    s = rneg ? -longint'(t) : longint'(t);
    for (int i = 0; i < NUM_TERMS; i++) begin
      f = (r2 * 64'(SIN_RCP[i])) >> 32;
      t = (t * f) >> 28;
      if (((i & 1) == 0) != rneg) s -= longint'(t);
      else s += longint'(t);
    end
    t = 64'(ONE_Q28);
    c = longint'(t);
    for (int i = 0; i < NUM_TERMS; i++) begin
      f = (r2 * 64'(COS_RCP[i])) >> 32;
      t = (t * f) >> 28;
      if ((i & 1) == 0) c -= longint'(t);
      else c += longint'(t);
    end
    res.sine = sat_q230(s);
    res.cosine = sat_q230(c);
    return res;
  endfunction

  // predict on accepted angles, compare on accepted results
  always @(posedge clk) begin
    trig_t want;
    int    n_err;
    n_err = 0;
    if (rst) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (angle_ch.valid && angle_ch.ready) trig_q.push_back(calc_trig(angle_ch.angle));
      if (result_ch.valid && result_ch.ready) begin
        if (trig_q.size() == 0) begin
          $display("%0t: unexpected word sine=%h cosine=%h", $time,
                   result_ch.sine, result_ch.cosine);
          n_err++;
        end else begin
          want = trig_q.pop_front();
          if (want.sine !== result_ch.sine) begin
            $display("%0t: sine expected %h actual %h", $time, want.sine, result_ch.sine);
            n_err++;
          end
          if (want.cosine !== result_ch.cosine) begin
            $display("%0t: cosine expected %h actual %h", $time, want.cosine,
                     result_ch.cosine);
            n_err++;
          end
        end
      end
      errors <= errors + n_err;
      pending <= trig_q.size();
    end
  end
endmodule

// ===== tb/sine_cosine_taylor_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sine_cosine_taylor_test: top of the sine/cosine series testbench
// Drives directed and random angles under several idle and stall mixes;
// the checker predicts and compares every result word.
// ---------------------------------------------------------------------------
module sine_cosine_taylor_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   send_idle = 0;
  int   sink_stall = 0;

  sct_angle_if  angle_ch ();
  sct_result_if result_ch ();

  sine_cosine_taylor dut (.clk(clk), .rst(rst), .angle_ch(angle_ch), .result_ch(result_ch));
  sct_scoreboard chk (.clk(clk), .rst(rst), .angle_ch(angle_ch), .result_ch(result_ch),
                      .errors(errors), .pending(pending));

  always #2 clk = ~clk;

  initial begin
    angle_ch.valid = 1'b0;
    angle_ch.angle = '0;
    result_ch.ready = 1'b0;
  end

  // receiver stalls at the current rate
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_stall);
  end

  // hand one angle word over, with random idle cycles first
  task automatic send_angle(input logic signed [31:0] a);
    while ($urandom_range(99) < send_idle) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= a;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    angle_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random angle: mostly in a few periods, sometimes full range
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000;
      2: return $signed($urandom_range(0, 32'h7000_0000)) - 32'sh3800_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  logic signed [31:0] directed_angles[] = '{
    32'sh0000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0000_0001, -32'sh0000_0001,
    32'sh0324_3F6A, -32'sh0324_3F6A, 32'sh0192_1FB5, -32'sh0192_1FB5,
    32'sh0648_7ED5, -32'sh0648_7ED5, 32'sh0324_3F6B, 32'sh0324_3F69, -32'sh0324_3F6B,
    32'sh0968_BE40, -32'sh0968_BE40, 32'sh0100_0000, -32'sh0100_0000,
    32'sh5555_5555, -32'sh5555_5556, 32'sh7A00_0000, -32'sh7A00_0000
  };

  initial begin
    int idle_set[4] = '{0, 56, 0, 29};
    int stall_set[4] = '{0, 0, 56, 29};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_angles[i]) send_angle(directed_angles[i]);
    // pause until all results are back
    drain_results();
    for (int p = 0; p < 4; p++) begin
      send_idle = idle_set[p];
      sink_stall = stall_set[p];
      for (int n = 0; n < 500; n++) send_angle(pick_angle());
      if (p == 1) drain_results();
    end
    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
